// ===== hw/rtl/binary_cross_entropy_loss_unit_macros.svh =====
// Assertion macros shared by the binary cross-entropy loss RTL.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef BINARY_CROSS_ENTROPY_LOSS_UNIT_MACROS_SVH
`define BINARY_CROSS_ENTROPY_LOSS_UNIT_MACROS_SVH

// same-cycle implication
`define BCE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bce assertion failed");

// next-cycle implication
`define BCE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bce assertion failed");

`endif

// ===== hw/rtl/bce_pkg.sv =====
// Types and constants of the binary cross-entropy loss unit.
// No dependencies.
`timescale 1ns / 1ps
package bce_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int IN_W         = 17;
    localparam int P_W          = 16;
    localparam int EPS_W        = 15;
    localparam int SUM_W        = 38;
    localparam int CNT_W        = 17;
    localparam int MEAN_W       = 20;
    localparam int LOG_W        = 20;
    localparam int MAX_ELEMENTS = 65536;
    localparam logic [IN_W-1:0] ONE = 17'h10000;
    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    typedef struct packed {
        logic [IN_W-1:0] y;
        logic [P_W-1:0]  p;
        logic [P_W-1:0]  q;
        logic            last;
    } fifo_item_t;
endpackage

// ===== hw/rtl/bce_front.sv =====
// Front end: clip register, label saturation and prediction clipping.
// Depends on bce_pkg.
`timescale 1ns / 1ps
module bce_front import bce_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [EPS_W-1:0] cfg_data,
    input  logic [IN_W-1:0]  label,
    input  logic [IN_W-1:0]  prediction,
    input  logic             last_item,
    output fifo_item_t       item
);
    logic [EPS_W-1:0] eps_reg;
    logic [IN_W-1:0]  eps;
    logic [IN_W-1:0]  p_clip;
    logic [IN_W-1:0]  q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_W'(1);
        end
        else if (cfg_write)
        begin
            eps_reg <= cfg_data;
        end
    end

    always_comb
    begin
        eps = (eps_reg == '0) ? IN_W'(1) : IN_W'(eps_reg);
        if (prediction < eps)
        begin
            p_clip = eps;
        end
        else if (prediction > ONE - eps)
        begin
            p_clip = ONE - eps;
        end
        else
        begin
            p_clip = prediction;
        end
        q_full    = ONE - p_clip;
        item.y    = (label > ONE) ? ONE : label;
        item.p    = p_clip[P_W-1:0];
        item.q    = q_full[P_W-1:0];
        item.last = last_item;
    end
endmodule

// ===== hw/rtl/bce_fifo.sv =====
// Short queue between front and back end.
// Depends on bce_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "binary_cross_entropy_loss_unit_macros.svh"
module bce_fifo import bce_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  fifo_item_t wr_item,
    output logic       full,
    input  logic       rd,
    output fifo_item_t rd_item,
    output logic       empty
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    fifo_item_t    mem [DEPTH];
    logic [AW-1:0] wptr_reg;
    logic [AW-1:0] rptr_reg;
    logic [AW:0]   cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - (AW+1)'(1);
            end
        end
    end

    `BCE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= (AW+1)'(DEPTH))
    `BCE_ASSERT_NXT(a_cnt_up, do_wr && !do_rd, cnt_reg == $past(cnt_reg) + (AW+1)'(1))
endmodule

// ===== hw/rtl/bce_log.sv =====
// Iterative fixed-point -ln(x / 2^16): 30 squaring steps, one product stage, one round stage.
// Depends on bce_pkg.
`timescale 1ns / 1ps
module bce_log import bce_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [P_W-1:0]   x,
    output logic             done,
    output logic [LOG_W-1:0] result
);
    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_SQ   = 2'd1;
    localparam logic [1:0] L_MUL  = 2'd2;
    localparam logic [1:0] L_RND  = 2'd3;
    localparam logic [34:0] NEG_BASE = 35'(FRAC_BITS) << 30;
    localparam logic [62:0] RND_BIAS = 63'd1 << 41;

    logic [1:0]       state_reg;
    logic [4:0]       step_reg;
    logic [31:0]      m_reg;
    logic [29:0]      frac_reg;
    logic [3:0]       msb_reg;
    logic [45:0]      plo_reg;
    logic [45:0]      phi_reg;
    logic             done_reg;
    logic [LOG_W-1:0] result_reg;
    logic [3:0]       msb_w;
    logic [63:0]      sq;
    logic [32:0]      sq_t;
    logic [34:0]      neg;
    logic [62:0]      total;

    always_comb
    begin
        msb_w = '0;
        for (int i = 1; i < P_W; i++)
        begin
            if (x[i])
            begin
                msb_w = 4'(i);
            end
        end
        sq    = m_reg * m_reg;
        sq_t  = sq[63:31];
        neg   = NEG_BASE - {1'b0, msb_reg, frac_reg};
        total = {phi_reg[45:0], 17'b0} + 63'(plo_reg) + RND_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= L_SQ;
                        step_reg  <= '0;
                    end
                end
                L_SQ:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd29)
                    begin
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    state_reg <= L_RND;
                end
                L_RND:
                begin
                    state_reg <= L_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                msb_reg  <= msb_w;
                m_reg    <= 32'(x) << (5'd31 - 5'(msb_w));
                frac_reg <= '0;
            end
            L_SQ:
            begin
                if (sq_t[32])
                begin
                    m_reg    <= sq_t[32:1];
                    frac_reg <= {frac_reg[28:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq_t[31:0];
                    frac_reg <= {frac_reg[28:0], 1'b0};
                end
            end
            L_MUL:
            begin
                plo_reg <= 46'(neg[16:0]) * 46'(LN2_Q28);
                phi_reg <= 46'(neg[34:17]) * 46'(LN2_Q28);
            end
            L_RND:
            begin
                result_reg <= total[61:42];
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

// ===== hw/rtl/bce_back.sv =====
// Back end: per-item loss, saturating accumulation, mean divide and result register.
// Depends on bce_pkg, bce_log and the assertion macro header.
`timescale 1ns / 1ps
`include "binary_cross_entropy_loss_unit_macros.svh"
module bce_back import bce_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  fifo_item_t        q_item,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output logic [MEAN_W-1:0] mean_loss,
    output logic [CNT_W-1:0]  element_count
);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_LOG  = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_ADD  = 3'd3;
    localparam logic [2:0] B_ACC  = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;
    localparam int DVD_W = SUM_W + 1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

    logic [2:0]        state_reg;
    fifo_item_t        cur_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [36:0]       ya_reg;
    logic [36:0]       yb_reg;
    logic [21:0]       term_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  run_cnt_reg;
    logic [5:0]        div_step_reg;
    logic              out_valid_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [CNT_W-1:0]  ecnt_reg;
    logic              log_start;
    logic              done_p;
    logic              done_q;
    logic [LOG_W-1:0]  nl_p;
    logic [LOG_W-1:0]  nl_q;
    logic [37:0]       term_sum;
    logic [SUM_W:0]    acc;
    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;

    assign log_start = (state_reg == B_IDLE) && !q_empty;
    assign q_rd      = log_start;

    bce_log u_log_p (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (q_item.p),
        .done   (done_p),
        .result (nl_p)
    );

    bce_log u_log_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (q_item.q),
        .done   (done_q),
        .result (nl_q)
    );

    always_comb
    begin
        term_sum  = 38'(ya_reg) + 38'(yb_reg) + 38'(ONE >> 1);
        acc       = {1'b0, sum_reg} + (SUM_W+1)'(term_reg);
        divisor   = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_step_reg  <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= B_LOG;
                    end
                end
                B_LOG:
                begin
                    if (done_p)
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_ADD;
                end
                B_ADD:
                begin
                    state_reg <= B_ACC;
                end
                B_ACC:
                begin
                    if (cnt_reg < CNT_MAX)
                    begin
                        sum_reg <= acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    state_reg <= cur_reg.last ? B_DIV : B_IDLE;
                end
                B_DIV:
                begin
                    if (div_step_reg == 6'(0))
                    begin
                        sum_reg <= '0;
                        cnt_reg <= '0;
                    end
                    div_step_reg <= div_step_reg + 6'd1;
                    if (div_step_reg == 6'(DVD_W))
                    begin
                        div_step_reg <= '0;
                        state_reg    <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (log_start)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == B_MUL)
        begin
            ya_reg <= 37'(cur_reg.y) * 37'(nl_p);
            yb_reg <= 37'(ONE - cur_reg.y) * 37'(nl_q);
        end
        if (state_reg == B_ADD)
        begin
            term_reg <= term_sum[37:16];
        end
        if (state_reg == B_DIV)
        begin
            if (div_step_reg == 6'(0))
            begin
                dvd_reg     <= {1'b0, sum_reg} + DVD_W'(divisor >> 1);
                dvs_reg     <= divisor;
                run_cnt_reg <= cnt_reg;
                rem_reg     <= '0;
                quot_reg    <= '0;
            end
            else
            begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                if (!trial_sub[CNT_W])
                begin
                    rem_reg  <= trial_sub[CNT_W-1:0];
                    quot_reg <= {quot_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial[CNT_W-1:0];
                    quot_reg <= {quot_reg[DVD_W-2:0], 1'b0};
                end
            end
        end
        if (state_reg == B_OUT && !out_valid_reg)
        begin
            mean_reg <= (|quot_reg[DVD_W-1:MEAN_W]) ? '1 : quot_reg[MEAN_W-1:0];
            ecnt_reg <= run_cnt_reg;
        end
    end

    assign empty         = !out_valid_reg;
    assign mean_loss     = mean_reg;
    assign element_count = ecnt_reg;

    `BCE_ASSERT_IMP(a_log_pair, 1'b1, done_p == done_q)
    `BCE_ASSERT_IMP(a_div_range, state_reg == B_DIV, div_step_reg <= 6'(DVD_W))
endmodule

// ===== hw/rtl/binary_cross_entropy_loss_unit.sv =====
// Top level of the streaming binary cross-entropy loss unit.
// Depends on bce_pkg, bce_front, bce_fifo and bce_back.
`timescale 1ns / 1ps
// Streams (label, prediction) pairs in unsigned Q1.16 and returns, on the item flagged
// last_item, the rounded mean loss in Q4.16 and the element count of the run. In the back
// end, each item is first taken from the queue. Then the two parallel iterative log units
// run until they report done: 30 squaring steps, a product stage, a round stage and the
// done register. Last come the weighting products, their sum and the accumulate. A last
// item then passes the bit-serial mean divide and the load of the result register, and it
// stays in the result stage while an earlier result is still waiting for pop. A four-entry
// queue lets the front accept items while the back end works; full rises when the queue
// holds four. Write clip_epsilon through cfg_write and cfg_data only while the unit is idle.
module binary_cross_entropy_loss_unit import bce_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [EPS_W-1:0]  cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [IN_W-1:0]   label,
    input  logic [IN_W-1:0]   prediction,
    input  logic              last_item,
    input  logic              pop,
    output logic              empty,
    output logic [MEAN_W-1:0] mean_loss,
    output logic [CNT_W-1:0]  element_count
);
    fifo_item_t front_item;
    fifo_item_t q_item;
    logic       q_empty;
    logic       q_rd;

    bce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .label      (label),
        .prediction (prediction),
        .last_item  (last_item),
        .item       (front_item)
    );

    bce_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_item (front_item),
        .full    (full),
        .rd      (q_rd),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    bce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .mean_loss     (mean_loss),
        .element_count (element_count)
    );
endmodule
